/* design/imconv_pkg.sv */
// imconv_pkg: shared constants, types and helpers of the 2-d convolution block
// no dependencies; imported by every module of the block
`default_nettype none

package imconv_pkg;

    localparam int MAX_KSIZE  = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 16;
    localparam int COEF_W    = 12;
    localparam int PROD_W    = PIX_W + COEF_W;
    localparam int COL_W     = PROD_W + $clog2(MAX_KSIZE);
    localparam int OUT_W     = 32;
    localparam int ROW_W     = 12;
    localparam int COL_IDX_W = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = $clog2(MAX_KSIZE);
    localparam int KS_W      = 3;
    localparam int HALF_W    = KS_W - 1;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int CFG_W     = MAX_KSIZE * COEF_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_COEFF_ROW0,
        CFG_COEFF_ROW1,
        CFG_COEFF_ROW2,
        CFG_COEFF_ROW3,
        CFG_COEFF_ROW4
    } cfg_reg_t;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef pix_t  pix_col_t  [MAX_KSIZE];
    typedef coef_t coef_col_t [MAX_KSIZE];

    typedef struct packed {
        logic shift;
        logic mul;
        logic sum;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [ROW_W-1:0]     row;
        logic [COL_IDX_W-1:0] col;
        logic [COL_IDX_W-1:0] addr;
        logic [SLOT_W-1:0]    slot;
    } pos_info_t;

    // half side of the kernel in use, oversized codes clamp to the largest kernel
    function automatic logic [HALF_W-1:0] kernel_half(input logic [KS_W-1:0] ks);
        logic [KS_W-1:0] k;
        begin
            k = (ks > KS_W'(MAX_KSIZE)) ? KS_W'(MAX_KSIZE) : ks;
            return k[KS_W-1:1];
        end
    endfunction

endpackage

`default_nettype wire

/* design/imconv_pos.sv */
// imconv_pos: raster position counters and per-item result decision
// depends on imconv_pkg
`default_nettype none

module imconv_pos (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          frame_start,
    input  wire logic [imconv_pkg::KS_W-1:0]     kernel_size,
    input  wire logic [imconv_pkg::WIDTH_W-1:0]  image_width,
    input  wire logic [imconv_pkg::HEIGHT_W-1:0] image_height,
    output imconv_pkg::pos_info_t              info
);
    import imconv_pkg::*;

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_IDX_W-1:0] col_reg, col_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic [WIDTH_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [HALF_W-1:0]    half;
    logic [KS_W-1:0]      span;
    logic [ROW_W-1:0]     r;
    logic [COL_IDX_W-1:0] c;
    logic [SLOT_W-1:0]    s;
    logic [WIDTH_W-1:0]   col_inc;
    logic [HEIGHT_W-1:0]  row_inc;

    always_comb
    begin
        priority if (image_width == '0)
            w_eff = WIDTH_W'(1);
        else if (image_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = image_width;

        priority if (image_height == '0)
            h_eff = HEIGHT_W'(1);
        else if (image_height > HEIGHT_W'(MAX_HEIGHT))
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            h_eff = image_height;

        half = kernel_half(kernel_size);
        span = {half, 1'b0};

        r = frame_start ? '0 : row_reg;
        c = frame_start ? '0 : col_reg;
        s = frame_start ? '0 : slot_reg;

        info.emit = (r >= ROW_W'(span)) && (c >= COL_IDX_W'(span))
                    && (HEIGHT_W'(r) < h_eff) && (WIDTH_W'(c) < w_eff);
        info.last = (HEIGHT_W'(r) == h_eff - HEIGHT_W'(1))
                    && (WIDTH_W'(c) == w_eff - WIDTH_W'(1));
        info.row  = r - ROW_W'(half);
        info.col  = c - COL_IDX_W'(half);
        info.addr = c;
        info.slot = s;

        col_inc   = WIDTH_W'(c) + WIDTH_W'(1);
        row_inc   = HEIGHT_W'(r) + HEIGHT_W'(1);
        row_next  = r;
        slot_next = s;
        col_next  = col_inc[COL_IDX_W-1:0];
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[ROW_W-1:0];
                slot_next = (s == SLOT_W'(MAX_KSIZE - 1)) ? '0 : s + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

/* design/imconv_line_buf.sv */
// imconv_line_buf: one line store bank per kernel row, registered read
// depends on imconv_pkg
`default_nettype none

module imconv_line_buf (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [imconv_pkg::SLOT_W-1:0]    slot,
    input  wire logic [imconv_pkg::COL_IDX_W-1:0] addr,
    input  wire imconv_pkg::pix_t                px,
    output imconv_pkg::pix_col_t                 rd
);
    import imconv_pkg::*;

    for (genvar b = 0; b < MAX_KSIZE; b++)
    begin : g_bank
        pix_t mem [MAX_WIDTH];

        // the bank of the current row is written, the others are read
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (slot == SLOT_W'(b))
                    mem[addr] <= px;
                else
                    rd[b] <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* design/imconv_cell.sv */
// imconv_cell: one window column with its multipliers and column adder
// depends on imconv_pkg
`default_nettype none

module imconv_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire imconv_pkg::cell_ctrl_t         ctrl,
    input  wire imconv_pkg::pix_col_t           col_in,
    input  wire imconv_pkg::coef_col_t          coef,
    output imconv_pkg::pix_col_t                col_out,
    output logic signed [imconv_pkg::COL_W-1:0] col_sum
);
    import imconv_pkg::*;

    pix_col_t                 col_reg;
    logic signed [PROD_W-1:0] prod_reg [MAX_KSIZE];
    logic signed [COL_W-1:0]  sum_reg, sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < MAX_KSIZE; d++)
            sum_next = sum_next + COL_W'(prod_reg[d]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '{default: '0};
        else if (ctrl.shift)
            col_reg <= col_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            for (int d = 0; d < MAX_KSIZE; d++)
                prod_reg[d] <= col_reg[d] * coef[d];
        end
        if (ctrl.sum)
            sum_reg <= sum_next;
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

`default_nettype wire

/* design/image_convolution_2d_top.sv */
// image_convolution_2d_top: streaming 2-d window correlation, top level
// depends on imconv_pkg, imconv_pos, imconv_line_buf, imconv_cell
//
// pixels enter in raster order on in_valid/in_ready with frame_start marking
// the first pixel of a frame; configuration registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only while
// no item is in flight, which the block does not enforce. each pixel shifts
// a new column into a row of five window cells; the column is the pixel and
// four line store banks read at the pixel's column. every interior position
// gives one item on out_valid/out_ready: filtered sum, centre row and column,
// and frame_last on the last pixel of the frame. border pixels give no item.
// throughput is one pixel per clock unless out_ready stalls the pipeline, set
// by the single port of each line store bank (one bank written, the others
// read, for each pixel). an accepted pixel passes the line store read, window
// shift, multiply and column sum registers; the output register then takes
// its final sum. when out_ready is low, pixels keep flowing until the four
// internal stages and the output register are full; then in_ready drops until
// the result is taken. reset clears the position to row 0 column 0, empties
// the pipeline and loads kernel_size 3, 1024 by 1024 and zero coefficients.
`default_nettype none

module image_convolution_2d_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [15:0]              pixel,
    input  wire logic                            frame_start,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [31:0]                   filtered,
    output logic [11:0]                          out_row,
    output logic [9:0]                           out_col,
    output logic                                 frame_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [imconv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [imconv_pkg::CFG_W-1:0]     cfg_data
);
    import imconv_pkg::*;

    logic [KS_W-1:0]     kernel_size_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [CFG_W-1:0]    coeff_reg [MAX_KSIZE];

    pos_info_t pos;
    logic      accept;

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    pos_info_t s1_info_reg, s2_info_reg, s3_info_reg, s4_info_reg;
    pix_t      px_s1_reg;
    logic      ready1, ready2, ready3, ready4;
    logic      adv1, adv2, adv3, adv4;

    pix_col_t   line_rd;
    pix_col_t   col0;
    pix_col_t   cell_col  [MAX_KSIZE];
    coef_col_t  cell_coef [MAX_KSIZE];
    logic signed [COL_W-1:0] col_sum [MAX_KSIZE];
    cell_ctrl_t ctrl;

    logic [HALF_W-1:0]       half;
    logic [KS_W-1:0]         span;
    logic signed [OUT_W-1:0] sum_all;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] filtered_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_IDX_W-1:0]    out_col_reg;
    logic                    frame_last_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg  <= KS_W'(3);
            image_width_reg  <= WIDTH_W'(1024);
            image_height_reg <= HEIGHT_W'(1024);
            coeff_reg        <= '{default: '0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_KERNEL_SIZE:  kernel_size_reg  <= cfg_data[KS_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_COEFF_ROW0:   coeff_reg[0]     <= cfg_data;
                CFG_COEFF_ROW1:   coeff_reg[1]     <= cfg_data;
                CFG_COEFF_ROW2:   coeff_reg[2]     <= cfg_data;
                CFG_COEFF_ROW3:   coeff_reg[3]     <= cfg_data;
                CFG_COEFF_ROW4:   coeff_reg[4]     <= cfg_data;
            endcase
        end
    end

    // pipeline handshake
    always_comb
    begin
        ready4 = !out_valid_reg || out_ready;
        adv4   = s4_valid_reg && ready4;
        ready3 = !s4_valid_reg || ready4;
        adv3   = s3_valid_reg && ready3;
        ready2 = !s3_valid_reg || ready3;
        ready1 = !s2_valid_reg || ready2;
        adv2   = s2_valid_reg && ready2;
        adv1   = s1_valid_reg && ready1;
    end

    // s1 holds the accepted pixel while the line stores are read
    assign in_ready = !s1_valid_reg || adv1;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctrl.shift = adv1;
        ctrl.mul   = adv2;
        ctrl.sum   = adv3;
    end

    imconv_pos u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .kernel_size  (kernel_size_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .info         (pos)
    );

    imconv_line_buf u_line_buf (
        .clk  (clk),
        .en   (accept),
        .slot (pos.slot),
        .addr (pos.addr),
        .px   (pixel),
        .rd   (line_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (adv1)
                s2_valid_reg <= 1'b1;
            else if (adv2)
                s2_valid_reg <= 1'b0;
            if (adv2)
                s3_valid_reg <= 1'b1;
            else if (adv3)
                s3_valid_reg <= 1'b0;
            if (adv3)
                s4_valid_reg <= 1'b1;
            else if (adv4)
                s4_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= pos;
            px_s1_reg   <= pixel;
        end
        if (adv1)
            s2_info_reg <= s1_info_reg;
        if (adv2)
            s3_info_reg <= s2_info_reg;
        if (adv3)
            s4_info_reg <= s3_info_reg;
    end

    // new window column, newest row first
    always_comb
    begin
        logic [SLOT_W:0] bi;
        for (int d = 0; d < MAX_KSIZE; d++)
        begin
            bi = (SLOT_W+1)'(s1_info_reg.slot) + (SLOT_W+1)'(MAX_KSIZE - d);
            if (bi >= (SLOT_W+1)'(MAX_KSIZE))
                bi = bi - (SLOT_W+1)'(MAX_KSIZE);
            if (d == 0)
                col0[d] = px_s1_reg;
            else
                col0[d] = line_rd[bi[SLOT_W-1:0]];
        end
    end

    // coefficient column per cell, window column k pairs with kernel column span-k
    assign half = kernel_half(kernel_size_reg);
    assign span = {half, 1'b0};

    always_comb
    begin
        logic [KS_W-1:0] ri;
        logic [KS_W-1:0] cj;
        for (int k = 0; k < MAX_KSIZE; k++)
        begin
            for (int d = 0; d < MAX_KSIZE; d++)
            begin
                ri = '0;
                cj = '0;
                cell_coef[k][d] = '0;
                if ((KS_W'(d) <= span) && (KS_W'(k) <= span))
                begin
                    ri = span - KS_W'(d);
                    cj = span - KS_W'(k);
                    cell_coef[k][d] = coeff_reg[ri][COEF_W*cj +: COEF_W];
                end
            end
        end
    end

    for (genvar k = 0; k < MAX_KSIZE; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            imconv_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .col_in  (col0),
                .coef    (cell_coef[k]),
                .col_out (cell_col[k]),
                .col_sum (col_sum[k])
            );
        end
        else
        begin : g_next
            imconv_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .col_in  (cell_col[k-1]),
                .coef    (cell_coef[k]),
                .col_out (cell_col[k]),
                .col_sum (col_sum[k])
            );
        end
    end

    always_comb
    begin
        sum_all = '0;
        for (int k = 0; k < MAX_KSIZE; k++)
            sum_all = sum_all + OUT_W'(col_sum[k]);
    end

    // output register, items without a result are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv4 && s4_info_reg.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s4_info_reg.emit)
        begin
            filtered_reg   <= sum_all;
            out_row_reg    <= s4_info_reg.row;
            out_col_reg    <= s4_info_reg.col;
            frame_last_reg <= s4_info_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign filtered   = filtered_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire

/* test/image_convolution_2d_top_tb.sv */
// image_convolution_2d_top_tb: self-checking bench for the streaming 2-d window correlation
// drives pixels and register writes over valid/ready, predicts every result in-bench
// depends on imconv_pkg and image_convolution_2d_top
`timescale 1ns / 1ps

module image_convolution_2d_top_tb;
    import imconv_pkg::*;

    typedef struct {
        logic signed [31:0] sum;
        logic [11:0]        row;
        logic [9:0]         col;
        logic               last;
    } conv_result_t;

    typedef enum {ROW_CFG, ROW_PIX} row_kind_t;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_kind_t;

    typedef struct {
        row_kind_t    kind;
        cfg_reg_t     idx;
        logic [59:0]  data;
        pix_t         pix;
        logic         fs;
        chk_kind_t    chk;
        conv_result_t want;
    } stim_row_t;

    localparam int NUM_PHASES = 16;
    localparam int PHASE_ITEMS = 88;
    localparam int PREFILL_W = PHASE_ITEMS;
    localparam logic [59:0] COEF_ALL_MIN = 60'h800800800800800;
    localparam logic [59:0] COEF_ALL_MAX = 60'h7FF7FF7FF7FF7FF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    pix_t                 pixel = '0;
    logic                 frame_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   filtered;
    logic [11:0]          out_row;
    logic [9:0]           out_col;
    logic                 frame_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    image_convolution_2d_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_last  (frame_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of registers and pixel history
    logic [2:0]   ks_q = 3'd3;
    logic [10:0]  width_q = 11'd1024;
    logic [12:0]  height_q = 13'd1024;
    logic [59:0]  coef_q [MAX_KSIZE];
    pix_t         line_mem [MAX_KSIZE][MAX_WIDTH];
    pix_t         win_q [MAX_KSIZE][MAX_KSIZE];
    int unsigned  row_pos = 0;
    int unsigned  col_pos = 0;

    conv_result_t pending_q [$];
    conv_result_t head_res;
    stim_row_t    dir_tbl [$];
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    function automatic bit conv_step(input pix_t p, input logic fs, output conv_result_t res);
        int unsigned w, hgt, ks, hh, span, r, c, slot;
        int          d, k, i, j;
        longint      acc;
        coef_t       cf;
        bit          hit;
        begin
            w = width_q;
            if (w < 1) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            hgt = height_q;
            if (hgt < 1) hgt = 1;
            if (hgt > MAX_HEIGHT) hgt = MAX_HEIGHT;
            ks = ks_q;
            if (ks > MAX_KSIZE) ks = MAX_KSIZE;
            hh = ks / 2;
            span = 2 * hh;
            if (fs)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
            slot = r % MAX_KSIZE;
            line_mem[slot][c] = p;
            for (d = 0; d < MAX_KSIZE; d++)
            begin
                for (k = MAX_KSIZE - 1; k > 0; k--)
                    win_q[d][k] = win_q[d][k-1];
                win_q[d][0] = line_mem[(slot + MAX_KSIZE - d) % MAX_KSIZE][c];
            end
            hit = 1'b0;
            res = '{sum: '0, row: '0, col: '0, last: 1'b0};
            if (r >= span && c >= span && r < hgt && col_pos < w)
            begin
                acc = 0;
                for (i = 0; i <= span; i++)
                    for (j = 0; j <= span; j++)
                    begin
                        cf = coef_q[i][12*j +: 12];
                        acc += longint'(win_q[span-i][span-j]) * longint'(cf);
                    end
                res.sum = acc[31:0];
                res.row = 12'(r - hh);
                res.col = 10'(c - hh);
                res.last = (r == hgt - 1) && (col_pos == w - 1);
                hit = 1'b1;
            end
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= hgt) row_pos = 0;
            end
            return hit;
        end
    endfunction

    // leaves cfg_valid high, the caller lowers it after the last write
    task automatic write_reg(input cfg_reg_t idx, input logic [59:0] v);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= v;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx)
                CFG_KERNEL_SIZE:  ks_q = v[2:0];
                CFG_IMAGE_WIDTH:  width_q = v[10:0];
                CFG_IMAGE_HEIGHT: height_q = v[12:0];
                default:          coef_q[int'(idx) - int'(CFG_COEFF_ROW0)] = v;
            endcase
        end
    endtask

    task automatic send_pixel(input pix_t p, input logic fs, input chk_kind_t chk,
                              input conv_result_t want);
        conv_result_t got;
        bit           hit;
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            pixel <= p;
            frame_start <= fs;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            hit = conv_step(p, fs, got);
            if (chk == CHK_MODEL && hit)
                pending_q.push_back(got);
            else if (chk == CHK_TYPED)
                pending_q.push_back(want);
        end
    endtask

    // pipeline drain before a register write
    task automatic settle();
        begin
            in_valid <= 1'b0;
            while (pending_q.size() != 0) @(posedge clk);
            repeat (10) @(posedge clk);
        end
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input logic [59:0] v);
        stim_row_t s;
        begin
            s.kind = ROW_CFG;
            s.idx = idx;
            s.data = v;
            s.pix = '0;
            s.fs = 1'b0;
            s.chk = CHK_NONE;
            s.want = '{sum: '0, row: '0, col: '0, last: 1'b0};
            dir_tbl.push_back(s);
        end
    endtask

    task automatic add_pix(input pix_t p, input logic fs, input chk_kind_t chk,
                           input logic signed [31:0] sum, input logic [11:0] row,
                           input logic [9:0] col, input logic last);
        stim_row_t s;
        begin
            s.kind = ROW_PIX;
            s.idx = CFG_KERNEL_SIZE;
            s.data = '0;
            s.pix = p;
            s.fs = fs;
            s.chk = chk;
            s.want = '{sum: sum, row: row, col: col, last: last};
            dir_tbl.push_back(s);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected item: sum %0d row %0d col %0d last %0b",
                             filtered, out_row, out_col, frame_last);
            end
            else
            begin
                head_res = pending_q.pop_front();
                if (filtered !== head_res.sum || out_row !== head_res.row ||
                    out_col !== head_res.col || frame_last !== head_res.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: exp sum %0d row %0d col %0d last %0b,",
                                  " got sum %0d row %0d col %0d last %0b"},
                                 head_res.sum, head_res.row, head_res.col, head_res.last,
                                 filtered, out_row, out_col, frame_last);
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    initial
    begin
        #5_000_000;
        $display("FAIL image_convolution_2d_top");
        $finish;
    end

    initial
    begin
        int            ph, n, d, k, r, style;
        logic [59:0]   cfg_vals [8];
        pix_t          p;
        logic          fs;
        bit            in_stream;
        conv_result_t  no_res;

        no_res = '{sum: '0, row: '0, col: '0, last: 1'b0};
        for (d = 0; d < MAX_KSIZE; d++)
        begin
            coef_q[d] = '0;
            for (k = 0; k < MAX_KSIZE; k++)
                win_q[d][k] = '0;
            for (k = 0; k < MAX_WIDTH; k++)
                line_mem[d][k] = '0;
        end

        // kernel 1: product of one pixel and one coefficient
        add_cfg(CFG_KERNEL_SIZE, 60'd1);
        add_cfg(CFG_IMAGE_WIDTH, 60'd1);
        add_cfg(CFG_IMAGE_HEIGHT, 60'd1);
        add_cfg(CFG_COEFF_ROW0, 60'h800);
        add_pix(-16'sd32768, 1'b1, CHK_TYPED, 32'sd67108864, 12'd0, 10'd0, 1'b1);
        add_pix(16'sd32767, 1'b0, CHK_TYPED, -32'sd67106816, 12'd0, 10'd0, 1'b1);
        add_pix(16'sd0, 1'b0, CHK_TYPED, 32'sd0, 12'd0, 10'd0, 1'b1);
        add_pix(-16'sd1, 1'b1, CHK_TYPED, 32'sd2048, 12'd0, 10'd0, 1'b1);
        add_cfg(CFG_COEFF_ROW0, 60'h7FF);
        add_pix(-16'sd32768, 1'b0, CHK_TYPED, -32'sd67076096, 12'd0, 10'd0, 1'b1);
        add_pix(16'sd32767, 1'b0, CHK_TYPED, 32'sd67074049, 12'd0, 10'd0, 1'b1);
        // kernel larger than the frame
        add_cfg(CFG_KERNEL_SIZE, 60'd3);
        add_cfg(CFG_IMAGE_WIDTH, 60'd2);
        add_cfg(CFG_IMAGE_HEIGHT, 60'd2);
        add_pix(16'sh1234, 1'b1, CHK_NONE, 0, 0, 0, 0);
        add_pix(-16'sh0567, 1'b0, CHK_NONE, 0, 0, 0, 0);
        add_pix(16'sh7FFF, 1'b0, CHK_NONE, 0, 0, 0, 0);
        add_pix(-16'sh8000, 1'b0, CHK_NONE, 0, 0, 0, 0);
        // even kernel code rounds up to 3
        add_cfg(CFG_KERNEL_SIZE, 60'd2);
        add_cfg(CFG_IMAGE_WIDTH, 60'd3);
        add_cfg(CFG_IMAGE_HEIGHT, 60'd3);
        add_cfg(CFG_COEFF_ROW0, 60'hFFF_FFF_C01_7FF_3A5);
        add_cfg(CFG_COEFF_ROW1, 60'h800_800_400_800_0FF);
        add_cfg(CFG_COEFF_ROW2, 60'h7FF_7FF_9C3_001_FFF);
        for (n = 0; n < 9; n++)
            add_pix(pix_t'(16'h8000 + n * 16'h1F37), n == 0, CHK_MODEL, 0, 0, 0, 0);
        // zero codes clamp to a 1 by 1 frame and kernel
        add_cfg(CFG_KERNEL_SIZE, 60'd0);
        add_cfg(CFG_IMAGE_WIDTH, 60'd0);
        add_cfg(CFG_IMAGE_HEIGHT, 60'd0);
        add_pix(16'sh7ABC, 1'b0, CHK_MODEL, 0, 0, 0, 0);
        add_pix(-16'sh2222, 1'b0, CHK_MODEL, 0, 0, 0, 0);
        // oversized codes clamp to the largest sizes
        add_cfg(CFG_KERNEL_SIZE, 60'd7);
        add_cfg(CFG_IMAGE_WIDTH, 60'd2047);
        add_cfg(CFG_IMAGE_HEIGHT, 60'd8191);
        add_pix(16'sh0101, 1'b1, CHK_NONE, 0, 0, 0, 0);
        add_pix(16'shFEFE, 1'b0, CHK_NONE, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // five rows fill every line store column that later frames reach
        write_reg(CFG_KERNEL_SIZE, 60'd5);
        write_reg(CFG_IMAGE_WIDTH, 60'(PREFILL_W));
        cfg_valid <= 1'b0;
        for (n = 0; n < MAX_KSIZE * PREFILL_W; n++)
            send_pixel(pix_t'($urandom_range(0, 65535)), n == 0, CHK_MODEL, no_res);
        settle();

        send_idle_pct = 6;
        recv_stall_pct = 6;
        in_stream = 1'b0;
        foreach (dir_tbl[n])
        begin
            if (dir_tbl[n].kind == ROW_CFG)
            begin
                if (in_stream)
                begin
                    settle();
                    in_stream = 1'b0;
                end
                write_reg(dir_tbl[n].idx, dir_tbl[n].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                in_stream = 1'b1;
                send_pixel(dir_tbl[n].pix, dir_tbl[n].fs, dir_tbl[n].chk, dir_tbl[n].want);
            end
        end
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            style = 0;
            if (ph < 2)
            begin
                // full-scale sums of both signs
                cfg_vals[0] = 60'd5;
                cfg_vals[1] = 60'd5;
                cfg_vals[2] = 60'd5;
                for (d = 0; d < MAX_KSIZE; d++)
                    cfg_vals[3+d] = COEF_ALL_MIN;
                style = ph + 1;
            end
            else
            begin
                r = $urandom_range(0, 9);
                cfg_vals[0] = (r < 8) ? 60'(2 * $urandom_range(0, 2) + 1)
                                      : 60'($urandom_range(0, 7));
                r = $urandom_range(0, 9);
                cfg_vals[1] = (r < 7) ? 60'($urandom_range(1, 12)) :
                              (r == 7) ? 60'd1024 :
                              (r == 8) ? 60'd0 : 60'($urandom_range(0, 2047));
                r = $urandom_range(0, 9);
                cfg_vals[2] = (r < 7) ? 60'($urandom_range(1, 10)) :
                              (r == 7) ? 60'd4096 :
                              (r == 8) ? 60'd0 : 60'($urandom_range(0, 8191));
                for (d = 0; d < MAX_KSIZE; d++)
                begin
                    r = $urandom_range(0, 9);
                    cfg_vals[3+d] = (r < 6) ? 60'({$urandom, $urandom}) :
                                    (r == 6) ? COEF_ALL_MIN :
                                    (r == 7) ? COEF_ALL_MAX :
                                    (r == 8) ? 60'd0 : 60'h400;
                end
                if (ph == 2)
                begin
                    cfg_vals[0] = 60'd1;
                    cfg_vals[1] = 60'd1;
                    cfg_vals[2] = 60'd4096;
                end
            end
            for (d = 0; d < 8; d++)
                write_reg(cfg_reg_t'(d), cfg_vals[d]);
            cfg_valid <= 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                case (style)
                    1: p = -16'sd32768;
                    2: p = 16'sd32767;
                    default:
                    begin
                        r = $urandom_range(0, 19);
                        p = (r == 0) ? -16'sd32768 : (r == 1) ? 16'sd32767
                                     : pix_t'($urandom_range(0, 65535));
                    end
                endcase
                // each phase opens a frame, a few restarts mid-frame
                if (n == 0)
                    fs = 1'b1;
                else
                    fs = ($urandom_range(0, 99) < 3);
                send_pixel(p, fs, CHK_MODEL, no_res);
            end
            settle();
        end

        if (err_count == 0 && pending_q.size() == 0)
            $display("PASS image_convolution_2d_top");
        else
            $display("FAIL image_convolution_2d_top");
        $finish;
    end

endmodule

/* sim.f */
design/imconv_pkg.sv
design/imconv_pos.sv
design/imconv_line_buf.sv
design/imconv_cell.sv
design/image_convolution_2d_top.sv
test/image_convolution_2d_top_tb.sv
